[sv/gdbd_pkg.sv]
// Shared types, constants and calendar functions for the Gregorian day-distance block.
// No dependencies; used by gdbd_lane, gdbd_merge and gregorian_days_between_dates_top.
package gdbd_pkg;

   localparam int unsigned YEAR_W   = 12;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned DAY_W    = 5;
   localparam int unsigned COUNT_W  = 20;
   localparam int unsigned SERIAL_W = 21;
   localparam int unsigned LIMIT_W  = 16;

   localparam logic [YEAR_W-1:0]   MIN_YEAR  = YEAR_W'(1900);
   localparam logic [LIMIT_W-1:0]  MAX_YEAR  = LIMIT_W'(4095);
   localparam logic [COUNT_W-1:0]  COUNT_MAX = '1;

   // Month codes
   localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
   localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
   localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
   localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
   localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
   localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

   typedef struct packed {
      logic [YEAR_W-1:0]  first_year;
      logic [MONTH_W-1:0] first_month;
      logic [DAY_W-1:0]   first_day;
      logic [YEAR_W-1:0]  second_year;
      logic [MONTH_W-1:0] second_month;
      logic [DAY_W-1:0]   second_day;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] day_count;
      logic               first_valid;
      logic               second_valid;
   } rsp_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } date_type;

   typedef struct packed {
      logic                ok;
      logic [SERIAL_W-1:0] serial;
   } lane_res_type;

   // floor(x / 25) for x < 1024, reciprocal multiply
   function automatic logic [5:0] div25_10(input logic [9:0] x);
      logic [20:0] p;
      p = 21'(x) * 21'd1311;
      return p[20:15];
   endfunction

   // floor(y / 25) for 12-bit y
   function automatic logic [7:0] div25_12(input logic [YEAR_W-1:0] y);
      logic [24:0] p;
      p = 25'(y) * 25'd5243;
      return p[24:17];
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         MON_FEB: len = leap ? 5'd29 : 5'd28;
         MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   // Days before the month in a March-based year: (153*mp + 2) / 5
   function automatic logic [8:0] month_off(input logic [MONTH_W-1:0] m);
      logic [8:0] off;
      case (m)
         MON_MAR: off = 9'd0;
         MON_APR: off = 9'd31;
         MON_MAY: off = 9'd61;
         MON_JUN: off = 9'd92;
         MON_JUL: off = 9'd122;
         MON_AUG: off = 9'd153;
         MON_SEP: off = 9'd184;
         MON_OCT: off = 9'd214;
         MON_NOV: off = 9'd245;
         MON_DEC: off = 9'd275;
         MON_JAN: off = 9'd306;
         MON_FEB: off = 9'd337;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

endpackage

[sv/gdbd_lane.sv]
// One date lane: validity check and serial day number, registered.
// Depends on gdbd_pkg.
module gdbd_lane
   import gdbd_pkg::*;
#(
   parameter logic [LIMIT_W-1:0] YEAR_LIMIT = MAX_YEAR
)
(
   input  logic         clock,
   input  logic         load,
   input  date_type     date,
   output lane_res_type res_ff
);

   lane_res_type            res_in;
   logic                    z25;
   logic                    leap;
   logic [7:0]              q25;
   logic [YEAR_W-1:0]       ya;
   logic [5:0]              q100;
   logic [5:0]              q400;
   logic [SERIAL_W:0]       sum;

   always_comb begin
      // leap: div by 4 and (not div by 25 or div by 16)
      q25  = div25_12(date.year);
      z25  = (13'(q25) * 13'd25) == 13'(date.year);
      leap = (date.year[1:0] == 2'b00) && (!z25 || (date.year[3:2] == 2'b00));

      res_in.ok = (date.year >= MIN_YEAR)
               && (LIMIT_W'(date.year) <= YEAR_LIMIT)
               && (date.month >= MON_JAN) && (date.month <= MON_DEC)
               && (date.day != '0)
               && (date.day <= month_len(date.month, leap));

      // Jan and Feb belong to the previous March-based year
      ya   = (date.month <= MON_FEB) ? date.year - YEAR_W'(1) : date.year;
      q100 = div25_10(ya[11:2]);
      q400 = div25_10({2'b00, ya[11:4]});
      sum  = 22'(ya) * 22'd365 + 22'(ya[11:2]) - 22'(q100) + 22'(q400)
           + 22'(month_off(date.month)) + 22'(date.day) - 22'd1;
      res_in.serial = sum[SERIAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

endmodule

[sv/gdbd_merge.sv]
// Merge stage: absolute difference of the two lane serials, saturation, invalid masking.
// Depends on gdbd_pkg.
module gdbd_merge
   import gdbd_pkg::*;
(
   input  logic         clock,
   input  logic         load,
   input  lane_res_type lane_a,
   input  lane_res_type lane_b,
   output rsp_type      res_ff
);

   rsp_type             res_in;
   logic [SERIAL_W-1:0] diff;

   always_comb begin
      diff = (lane_a.serial >= lane_b.serial) ? lane_a.serial - lane_b.serial
                                              : lane_b.serial - lane_a.serial;
      res_in.first_valid  = lane_a.ok;
      res_in.second_valid = lane_b.ok;
      if (!(lane_a.ok && lane_b.ok)) begin
         res_in.day_count = '0;
      end else if (diff > SERIAL_W'(COUNT_MAX)) begin
         res_in.day_count = COUNT_MAX;
      end else begin
         res_in.day_count = diff[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

endmodule

[sv/gregorian_days_between_dates_top.sv]
// Each item passes the lane stage, then the merge stage, before its result is valid.
// Throughput: one item per cycle; the two-stage pipeline keeps accepting while rsp_stall
// is low, and keeps taking one more item while a finished result waits.
// Reset (synchronous, active high) clears the stage valid bits only; payload is not reset.
// Depends on gdbd_pkg, gdbd_lane, gdbd_merge.
module gregorian_days_between_dates_top
   import gdbd_pkg::*;
#(
   // Latest year that still counts as a valid date
   parameter logic [LIMIT_W-1:0] YEAR_LIMIT = MAX_YEAR
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Stage occupancy
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s1_load, s2_load;

   date_type     date_a, date_b;
   lane_res_type lane_a_ff, lane_b_ff;

   // Output stage moves when empty or being drained; lane stage moves when it
   // is empty or its item moves on. This gives a skid of one item under stall.
   assign s2_load   = !rsp_valid_ff || !rsp_stall;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign req_stall = !s1_load;

   assign s1_valid_in  = s1_load ? req_valid : s1_valid_ff;
   assign rsp_valid_in = s2_load ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Split the item into the two dates, one per lane
   assign date_a = '{year: req_data.first_year, month: req_data.first_month,
                     day: req_data.first_day};
   assign date_b = '{year: req_data.second_year, month: req_data.second_month,
                     day: req_data.second_day};

   gdbd_lane #(
      .YEAR_LIMIT (YEAR_LIMIT)
   ) u_lane_a (
      .clock  (clock),
      .load   (s1_load && req_valid),
      .date   (date_a),
      .res_ff (lane_a_ff)
   );

   gdbd_lane #(
      .YEAR_LIMIT (YEAR_LIMIT)
   ) u_lane_b (
      .clock  (clock),
      .load   (s1_load && req_valid),
      .date   (date_b),
      .res_ff (lane_b_ff)
   );

   // Combine lane serials into the day count
   gdbd_merge u_merge (
      .clock  (clock),
      .load   (s2_load && s1_valid_ff),
      .lane_a (lane_a_ff),
      .lane_b (lane_b_ff),
      .res_ff (rsp_data)
   );

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // An invalid date always forces a zero count
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !(rsp_data.first_valid && rsp_data.second_valid)
      |-> rsp_data.day_count == '0)
      else $error("nonzero count with an invalid date");

   // Input only backs up when both stages are full and the output is stalled
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled with room in the pipeline");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");
`endif

endmodule
